// ----- src/shs_pkg.sv -----
// shared types, constants and round functions for the sha-256 stream hasher
package shs_pkg;

    localparam logic [2:0] MAX_BYTES  = 3'd4;
    localparam logic [5:0] PAD_LIMIT  = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_EXTRA,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic       absorb;
        logic       insert;
        logic       pad;
        logic       len;
        logic       round;
        logic       fold;
        logic       restart;
        logic [5:0] step;
    } shs_cmd_t;

    typedef struct packed {
        logic full;
        logic src_end;
        logic hold_left;
        logic hold_end;
        logic pad_fits;
    } shs_status_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

// ----- src/shs_dp.sv -----
// datapath: block store, message schedule, round registers, chain value and bit count
module shs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         data_word,
    input  logic [2:0]          byte_count,
    input  logic                message_end,
    input  shs_pkg::shs_cmd_t   cmd,
    output shs_pkg::shs_status_t st,
    output logic [31:0]         digest_word,
    output logic                status
);
    import shs_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] hold_data_reg, hold_data_next;
    logic [2:0]  hold_cnt_reg, hold_cnt_next;
    logic        hold_end_reg, hold_end_next;

    logic [2:0]  in_cnt;
    logic [31:0] src_data;
    logic [2:0]  src_cnt;
    logic        src_end;
    logic [6:0]  room;
    logic [2:0]  take;
    logic [6:0]  fill_sum;
    logic [64:0] len_sum;
    logic [31:0] sched;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign in_cnt   = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
    assign src_data = cmd.absorb ? data_word : hold_data_reg;
    assign src_cnt  = cmd.absorb ? in_cnt : hold_cnt_reg;
    assign src_end  = cmd.absorb ? message_end : hold_end_reg;
    assign room     = 7'd64 - {1'b0, fill_reg};
    assign take     = ({4'd0, src_cnt} < room) ? src_cnt : room[2:0];
    assign fill_sum = {1'b0, fill_reg} + {4'd0, take};
    assign len_sum  = {1'b0, bitlen_reg} + {59'd0, in_cnt, 3'b000};

    assign st.full      = fill_sum[6];
    assign st.src_end   = src_end;
    assign st.hold_left = (hold_cnt_reg != 3'd0);
    assign st.hold_end  = hold_end_reg;
    assign st.pad_fits  = (fill_reg < PAD_LIMIT);

    assign digest_word = chain_reg[cmd.step[2:0]];
    assign status      = ovf_reg;

    assign sched = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign ch    = v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6]));
    assign maj   = (v_reg[0] & v_reg[1]) | ((v_reg[0] | v_reg[1]) & v_reg[2]);
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[cmd.step] + w_reg[0];
    assign t2    = big_sigma0(v_reg[0]) + maj;

    // block store and message schedule
    always_comb
    begin
        logic [5:0]  off;
        logic [31:0] shifted;
        off     = '0;
        shifted = '0;
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = sched;
        end
        else if (cmd.insert)
        begin
            for (int p = 0; p < 64; p++)
            begin
                off     = 6'(p) - fill_reg;
                shifted = src_data << {off[1:0], 3'b000};
                if (off < {3'd0, take})
                begin
                    w_next[p >> 2][(31 - 8 * (p & 3)) -: 8] = shifted[31:24];
                end
            end
        end
        else if (cmd.pad)
        begin
            for (int p = 0; p < 64; p++)
            begin
                if (6'(p) == fill_reg)
                begin
                    w_next[p >> 2][(31 - 8 * (p & 3)) -: 8] = PAD_BYTE;
                end
                else if (6'(p) > fill_reg)
                begin
                    w_next[p >> 2][(31 - 8 * (p & 3)) -: 8] = 8'd0;
                end
            end
            if (st.pad_fits)
            begin
                w_next[14] = bitlen_reg[63:32];
                w_next[15] = bitlen_reg[31:0];
            end
        end
        else if (cmd.len)
        begin
            for (int i = 0; i < 14; i++)
            begin
                w_next[i] = 32'd0;
            end
            w_next[14] = bitlen_reg[63:32];
            w_next[15] = bitlen_reg[31:0];
        end
    end

    // working variables and chain value
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_next[i]     = chain_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (cmd.round)
        begin
            v_next[0] = t1 + t2;
            v_next[1] = v_reg[0];
            v_next[2] = v_reg[1];
            v_next[3] = v_reg[2];
            v_next[4] = v_reg[3] + t1;
            v_next[5] = v_reg[4];
            v_next[6] = v_reg[5];
            v_next[7] = v_reg[6];
        end
        if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = INIT_HASH[i];
            end
        end
    end

    // fill, bit count and leftover bytes
    always_comb
    begin
        fill_next      = fill_reg;
        bitlen_next    = bitlen_reg;
        ovf_next       = ovf_reg;
        hold_data_next = hold_data_reg;
        hold_cnt_next  = hold_cnt_reg;
        hold_end_next  = hold_end_reg;
        if (cmd.absorb)
        begin
            bitlen_next = len_sum[63:0];
            ovf_next    = ovf_reg | len_sum[64];
        end
        if (cmd.insert)
        begin
            fill_next      = fill_sum[5:0];
            hold_data_next = src_data << {take, 3'b000};
            hold_cnt_next  = src_cnt - take;
            hold_end_next  = src_end;
        end
        else if (cmd.pad)
        begin
            fill_next = 6'd0;
        end
        if (cmd.restart)
        begin
            fill_next   = 6'd0;
            bitlen_next = 64'd0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
            fill_reg   <= 6'd0;
            bitlen_reg <= 64'd0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
        hold_data_reg <= hold_data_next;
        hold_cnt_reg  <= hold_cnt_next;
        hold_end_reg  <= hold_end_next;
    end

endmodule

// ----- src/shs_ctrl.sv -----
// controller: sequences word insertion, padding, compression rounds and digest output
module shs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           word_index,
    output logic                 digest_last,
    input  shs_pkg::shs_status_t st,
    output shs_pkg::shs_cmd_t    cmd
);
    import shs_pkg::*;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [5:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DATA;
            step_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    assign word_index  = step_reg[2:0];
    assign digest_last = (step_reg[2:0] == LAST_WORD);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.absorb = 1'b1;
                    cmd.insert = 1'b1;
                    if (st.full)
                    begin
                        phase_next = PH_DATA;
                        step_next  = 6'd0;
                        state_next = S_ROUND;
                    end
                    else if (st.src_end)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                if (st.full)
                begin
                    phase_next = PH_DATA;
                    step_next  = 6'd0;
                    state_next = S_ROUND;
                end
                else if (st.src_end)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAD:
            begin
                cmd.pad    = 1'b1;
                phase_next = st.pad_fits ? PH_FINAL : PH_EXTRA;
                step_next  = 6'd0;
                state_next = S_ROUND;
            end
            S_LEN:
            begin
                cmd.len    = 1'b1;
                phase_next = PH_FINAL;
                step_next  = 6'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_ROUND)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold  = 1'b1;
                step_next = 6'd0;
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        if (st.hold_left)
                        begin
                            state_next = S_INSERT;
                        end
                        else if (st.hold_end)
                        begin
                            state_next = S_PAD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    PH_EXTRA:
                    begin
                        state_next = S_LEN;
                    end
                    PH_FINAL:
                    begin
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    step_next = step_reg + 6'd1;
                    if (step_reg[2:0] == LAST_WORD)
                    begin
                        cmd.restart = 1'b1;
                        step_next   = 6'd0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sha256_stream_hasher.sv -----
// top level of the sha-256 stream hasher: controller and datapath
// a word is taken while idle; one that completes a 64-byte block adds a compression
// (64 rounds, one chain update), plus an insert step when its bytes spill over
// a message end adds a padding step and a compression, plus another for an extra length block,
// then eight digest words at one per cycle while out_ready is high; no word is taken meanwhile
// reset loads the initial hash values and clears the byte fill, bit count and overflow flag
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last,
    output logic        status
);
    import shs_pkg::*;

    shs_cmd_t    cmd;
    shs_status_t st;

    shs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_index  (word_index),
        .digest_last (digest_last),
        .st          (st),
        .cmd         (cmd)
    );

    shs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .message_end (message_end),
        .cmd         (cmd),
        .st          (st),
        .digest_word (digest_word),
        .status      (status)
    );

endmodule

// ----- src/shs_chk.sv -----
// port-level checker for the sha-256 stream hasher and its bind
module shs_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        digest_last,
    input logic        status
);

    // digest held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word)
            && $stable(word_index) && $stable(status))
        else $error("digest changed while stalled");

    // no input word taken while the digest is shown
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during digest output");

    // last flag marks word seven
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digest_last == (word_index == 3'd7)))
        else $error("digest_last does not match word_index");

    // digest words come in order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !digest_last |=>
            out_valid && (word_index == $past(word_index) + 3'd1))
        else $error("digest word order broken");

    // output ends after the last word
    a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && digest_last |=> !out_valid && in_ready)
        else $error("output continues after last digest word");

endmodule

bind sha256_stream_hasher shs_chk u_shs_chk (.*);
